[rtl/tdpt_pkg.sv]
// Package for the trial-division prime tester.
// Shared width constant, controller state type and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package tdpt_pkg;

   // Default width of the tested number.
   localparam int NumWidthDefault = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_TEST,
      ST_DONE
   } tdpt_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic load;        // capture candidate, divisor = 2, square = 4
      logic div_start;   // clear remainder, arm bit counter
      logic div_step;    // one restoring-division step
      logic advance;     // next divisor, update its square
      logic verdict_we;  // write the prime flag
      logic verdict;
      logic publish;     // move result into the output register
   } tdpt_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic below_two;   // candidate below two
      logic sq_over;     // divisor squared exceeds candidate
      logic div_last;    // division step counter at its last bit
      logic rem_zero;    // remainder is zero
      logic out_free;    // output register empty or being taken
   } tdpt_status_type;

endpackage

`default_nettype wire

[rtl/tdpt_ctrl.sv]
// Controller for the trial-division prime tester.
// Sequences load, bound check, bit-serial division and result hand-off.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  tdpt_pkg::tdpt_status_type status,
   output tdpt_pkg::tdpt_cmd_type    cmd
);

   tdpt_pkg::tdpt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_valid) state_in = tdpt_pkg::ST_CHECK;
         end
         tdpt_pkg::ST_CHECK: begin
            if (status.below_two || status.sq_over) state_in = tdpt_pkg::ST_DONE;
            else state_in = tdpt_pkg::ST_DIVIDE;
         end
         tdpt_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = tdpt_pkg::ST_TEST;
         end
         tdpt_pkg::ST_TEST: begin
            if (status.rem_zero) state_in = tdpt_pkg::ST_DONE;
            else state_in = tdpt_pkg::ST_CHECK;
         end
         tdpt_pkg::ST_DONE: begin
            if (status.out_free) state_in = tdpt_pkg::ST_IDLE;
         end
         default: state_in = tdpt_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         tdpt_pkg::ST_CHECK: begin
            if (status.below_two) begin
               cmd.verdict_we = 1'b1;
               cmd.verdict    = 1'b0;
            end else if (status.sq_over) begin
               cmd.verdict_we = 1'b1;
               cmd.verdict    = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         tdpt_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         tdpt_pkg::ST_TEST: begin
            if (status.rem_zero) begin
               cmd.verdict_we = 1'b1;
               cmd.verdict    = 1'b0;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         tdpt_pkg::ST_DONE: begin
            cmd.publish = status.out_free;
         end
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/tdpt_dp.sv]
// Datapath for the trial-division prime tester.
// Candidate, divisor and its square, a restoring remainder unit and the output register.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_dp #(
   parameter int NUM_WIDTH = tdpt_pkg::NumWidthDefault
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire [NUM_WIDTH-1:0]        req_candidate,
   input  wire                        rsp_ready,
   output logic                       rsp_valid,
   output logic [NUM_WIDTH-1:0]       rsp_tested_value,
   output logic                       rsp_is_prime,
   input  tdpt_pkg::tdpt_cmd_type     cmd,
   output tdpt_pkg::tdpt_status_type  status
);

   localparam int CntWidth = $clog2(NUM_WIDTH);
   localparam int SqWidth  = 2 * NUM_WIDTH;

   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] d_ff, d_in;
   logic [SqWidth-1:0]   sq_ff, sq_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 prime_ff, prime_in;
   logic [NUM_WIDTH-1:0] out_value_ff, out_value_in;
   logic                 out_prime_ff, out_prime_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [NUM_WIDTH:0]   trial;
   logic [NUM_WIDTH:0]   diff;

   // One restoring step: shift in the next candidate bit, subtract if it fits.
   assign trial = {rem_ff, n_ff[cnt_ff]};
   assign diff  = trial - {1'b0, d_ff};

   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      prime_in     = prime_ff;
      out_value_in = out_value_ff;
      out_prime_in = out_prime_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load) begin
         n_in  = req_candidate;
         d_in  = NUM_WIDTH'(2);
         sq_in = SqWidth'(4);
      end
      if (cmd.div_start) begin
         rem_in = '0;
         cnt_in = CntWidth'(NUM_WIDTH - 1);
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, d_ff}) rem_in = diff[NUM_WIDTH-1:0];
         else rem_in = trial[NUM_WIDTH-1:0];
         if (cnt_ff != '0) cnt_in = cnt_ff - CntWidth'(1);
      end
      if (cmd.advance) begin
         // (d+1)^2 = d^2 + 2d + 1
         d_in  = d_ff + NUM_WIDTH'(1);
         sq_in = sq_ff + SqWidth'({d_ff, 1'b1});
      end
      if (cmd.verdict_we) prime_in = cmd.verdict;

      if (cmd.publish) begin
         out_value_in = n_ff;
         out_prime_in = prime_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      prime_ff     <= prime_in;
      out_value_ff <= out_value_in;
      out_prime_ff <= out_prime_in;
   end

   assign status.below_two = (n_ff[NUM_WIDTH-1:1] == '0);
   assign status.sq_over   = (sq_ff > {{NUM_WIDTH{1'b0}}, n_ff});
   assign status.div_last  = (cnt_ff == '0);
   assign status.rem_zero  = (rem_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tested_value = out_value_ff;
   assign rsp_is_prime     = out_prime_ff;

endmodule

`default_nettype wire

[rtl/trial_division_prime_test.sv]
// Trial-division primality tester: takes one unsigned NUM_WIDTH-bit candidate per request
// and returns the candidate echoed with a prime flag; 0 and 1 are reported not prime.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_dp.
//
// Divisors run upward from 2 while divisor squared does not exceed the candidate; the test
// stops at the first divisor that leaves no remainder. One request is worked at a time.
// Each divisor takes one bound check, NUM_WIDTH steps of the bit-serial restoring
// remainder unit and one remainder test; the last divisor tried is at most
// floor(sqrt(candidate)). The result sits in an output register, so a new request is
// taken while the previous result waits on rsp_ready. The square of the divisor is
// kept incrementally (adding 2d+1), so no multiplier is used.
`default_nettype none

module trial_division_prime_test #(
   parameter int NUM_WIDTH = tdpt_pkg::NumWidthDefault
) (
   input  wire                  clock,
   input  wire                  reset,
   // request channel
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire [NUM_WIDTH-1:0]  req_candidate,
   // response channel
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [NUM_WIDTH-1:0] rsp_tested_value,
   output logic                 rsp_is_prime
);

   tdpt_pkg::tdpt_cmd_type    cmd;
   tdpt_pkg::tdpt_status_type status;

   // Sequencer: idle -> check bound -> divide -> test remainder -> ... -> hand off
   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, remainder unit and output register
   tdpt_dp #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_candidate    (req_candidate),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_tested_value (rsp_tested_value),
      .rsp_is_prime     (rsp_is_prime),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

[rtl/tdpt_checker.sv]
// Port-level checks for the trial-division prime tester, bound to the top level.
// Depends on trial_division_prime_test and tdpt_pkg.
`default_nettype none

module tdpt_checker #(
   parameter int NUM_WIDTH = tdpt_pkg::NumWidthDefault
) (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input wire [NUM_WIDTH-1:0] rsp_tested_value,
   input wire                 rsp_is_prime
);

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tested_value)
                                  && $stable(rsp_is_prime))
      else $error("response changed while stalled");

   // A prime is at least two.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime |-> rsp_tested_value[NUM_WIDTH-1:1] != '0)
      else $error("zero or one reported prime");

   // Even numbers other than two are composite.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tested_value[0] && rsp_tested_value != NUM_WIDTH'(2)
      |-> !rsp_is_prime)
      else $error("even number reported prime");

   // Taking a request makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   // No result appears right after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response raised too early");

endmodule

bind trial_division_prime_test tdpt_checker #(
   .NUM_WIDTH (NUM_WIDTH)
) u_tdpt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_tested_value (rsp_tested_value),
   .rsp_is_prime     (rsp_is_prime)
);

`default_nettype wire
